[rtl/lfu_pkg.sv]
// shared types and constants for the lfu cache with lru tie break
// used by lfu_ctrl, lfu_dp and lfu_cache_lru_tiebreak; no dependencies
package lfu_pkg;

    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_COUNT_BITS = 16;
    localparam int CAP_W          = 5;
    localparam int DATA_W         = 32;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
    localparam logic              REQ_GET    = 1'b0;
    localparam logic              REQ_PUT    = 1'b1;
    localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic scan;
        logic update;
        logic restart;
        logic finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic do_update;
    } dp_sts_t;

endpackage

[rtl/lfu_ctrl.sv]
// request sequencer: idle, search pass, update pass, result hand-off
// depends on lfu_pkg
module lfu_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  lfu_pkg::dp_sts_t  sts,
    output lfu_pkg::ctl_cmd_t cmd
);

    lfu_pkg::state_t state_reg;
    lfu_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfu_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            lfu_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = lfu_pkg::ST_SEARCH;
                end
            end
            lfu_pkg::ST_SEARCH:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    if (sts.do_update)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = lfu_pkg::ST_UPDATE;
                    end
                    else
                    begin
                        state_next = lfu_pkg::ST_FINISH;
                    end
                end
            end
            lfu_pkg::ST_UPDATE:
            begin
                cmd.scan   = 1'b1;
                cmd.update = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = lfu_pkg::ST_FINISH;
                end
            end
            lfu_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = lfu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lfu_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

[rtl/lfu_dp.sv]
// entry store, scan pipeline, victim/match tracking and result register
// depends on lfu_pkg
module lfu_dp #(
    parameter int ENTRIES    = lfu_pkg::DEF_ENTRIES,
    parameter int COUNT_BITS = lfu_pkg::DEF_COUNT_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  lfu_pkg::ctl_cmd_t                cmd,
    output lfu_pkg::dp_sts_t                 sts,
    input  logic                             cfg_we,
    input  logic [lfu_pkg::CAP_W-1:0]        cfg_data,
    input  logic                             req_type,
    input  logic [lfu_pkg::DATA_W-1:0]       key,
    input  logic [lfu_pkg::DATA_W-1:0]       value,
    output logic                             hit,
    output logic [lfu_pkg::DATA_W-1:0]       read_value,
    output logic                             evicted,
    output logic [lfu_pkg::DATA_W-1:0]       evicted_key
);

    localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CAPW = (CW > lfu_pkg::CAP_W) ? CW : lfu_pkg::CAP_W;
    localparam int DW   = lfu_pkg::DATA_W;

    logic [DW-1:0]         key_mem  [ENTRIES];
    logic [DW-1:0]         val_mem  [ENTRIES];
    logic [COUNT_BITS-1:0] cnt_mem  [ENTRIES];
    logic [IW-1:0]         rank_mem [ENTRIES];
    logic [ENTRIES-1:0]    valid_reg;

    logic [lfu_pkg::CAP_W-1:0] capacity_reg;
    logic [CW-1:0]             occ_reg;

    logic          req_reg;
    logic [DW-1:0] key_reg;
    logic [DW-1:0] val_reg;

    logic [CW-1:0] scan_cnt_reg;
    logic          pend_vld_reg;
    logic [IW-1:0] pend_idx_reg;
    logic          issue;
    logic [IW-1:0] rd_idx;

    logic [DW-1:0]         rd_key_reg;
    logic [DW-1:0]         rd_val_reg;
    logic [COUNT_BITS-1:0] rd_cnt_reg;
    logic [IW-1:0]         rd_rank_reg;

    logic                  match_reg;
    logic [IW-1:0]         match_idx_reg;
    logic [DW-1:0]         match_val_reg;
    logic [IW-1:0]         match_rank_reg;
    logic                  free_reg;
    logic [IW-1:0]         free_idx_reg;
    logic                  vic_reg;
    logic [IW-1:0]         vic_idx_reg;
    logic [COUNT_BITS-1:0] vic_cnt_reg;
    logic [IW-1:0]         vic_rank_reg;
    logic [DW-1:0]         vic_key_reg;

    logic          hit_reg;
    logic [DW-1:0] read_value_reg;
    logic          evicted_reg;
    logic [DW-1:0] evicted_key_reg;

    logic [CAPW-1:0] cap_ext;
    logic [CAPW-1:0] cap_eff;
    logic            cap_zero;
    logic            touch;
    logic            put_miss;
    logic            evict;
    logic            insert;
    logic [IW-1:0]   ins_idx;

    logic                  cur_valid;
    logic                  search_en;
    logic                  wr_en;
    logic                  new_valid;
    logic [DW-1:0]         new_key;
    logic [DW-1:0]         new_val;
    logic [COUNT_BITS-1:0] new_cnt;
    logic [IW-1:0]         new_rank;

    assign issue     = cmd.scan && (scan_cnt_reg != CW'(ENTRIES));
    assign rd_idx    = scan_cnt_reg[IW-1:0];
    assign cur_valid = valid_reg[pend_idx_reg];
    assign search_en = cmd.scan && !cmd.update && pend_vld_reg;
    assign wr_en     = cmd.update && pend_vld_reg;

    assign sts.scan_done = (scan_cnt_reg == CW'(ENTRIES)) && !pend_vld_reg;
    assign sts.do_update = touch || insert;

    // request decision from the search results
    always_comb
    begin
        cap_ext  = CAPW'(capacity_reg);
        cap_eff  = (cap_ext > CAPW'(ENTRIES)) ? CAPW'(ENTRIES) : cap_ext;
        cap_zero = (cap_eff == '0);
        touch    = match_reg && ((req_reg == lfu_pkg::REQ_GET) || !cap_zero);
        put_miss = (req_reg == lfu_pkg::REQ_PUT) && !cap_zero && !match_reg;
        evict    = put_miss && vic_reg && (CAPW'(occ_reg) >= cap_eff);
        insert   = put_miss && (evict || free_reg);
        if (evict && !(free_reg && (free_idx_reg < vic_idx_reg)))
        begin
            ins_idx = vic_idx_reg;
        end
        else
        begin
            ins_idx = free_idx_reg;
        end
    end

    // new contents of the entry under the update pass
    always_comb
    begin
        new_valid = cur_valid;
        new_key   = rd_key_reg;
        new_val   = rd_val_reg;
        new_cnt   = rd_cnt_reg;
        new_rank  = rd_rank_reg;
        if (touch)
        begin
            if (pend_idx_reg == match_idx_reg)
            begin
                new_rank = '0;
                if (rd_cnt_reg != {COUNT_BITS{1'b1}})
                begin
                    new_cnt = rd_cnt_reg + COUNT_BITS'(1);
                end
                if (req_reg == lfu_pkg::REQ_PUT)
                begin
                    new_val = val_reg;
                end
            end
            else if (cur_valid && (rd_rank_reg < match_rank_reg))
            begin
                new_rank = rd_rank_reg + IW'(1);
            end
        end
        else if (insert)
        begin
            if (pend_idx_reg == ins_idx)
            begin
                new_valid = 1'b1;
                new_key   = key_reg;
                new_val   = val_reg;
                new_cnt   = COUNT_BITS'(1);
                new_rank  = '0;
            end
            else if (evict && (pend_idx_reg == vic_idx_reg))
            begin
                new_valid = 1'b0;
            end
            else if (cur_valid && !(evict && (rd_rank_reg > vic_rank_reg)))
            begin
                new_rank = rd_rank_reg + IW'(1);
            end
        end
    end

    // entry memories, registered read
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_key_reg  <= key_mem[rd_idx];
            rd_val_reg  <= val_mem[rd_idx];
            rd_cnt_reg  <= cnt_mem[rd_idx];
            rd_rank_reg <= rank_mem[rd_idx];
        end
        if (wr_en)
        begin
            key_mem[pend_idx_reg]  <= new_key;
            val_mem[pend_idx_reg]  <= new_val;
            cnt_mem[pend_idx_reg]  <= new_cnt;
            rank_mem[pend_idx_reg] <= new_rank;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            capacity_reg <= lfu_pkg::CAP_RESET;
            occ_reg      <= '0;
            scan_cnt_reg <= '0;
            pend_vld_reg <= 1'b0;
            pend_idx_reg <= '0;
            match_reg    <= 1'b0;
            free_reg     <= 1'b0;
            vic_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_data;
            end
            if (cmd.capture || cmd.restart)
            begin
                scan_cnt_reg <= '0;
                pend_vld_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                if (issue)
                begin
                    scan_cnt_reg <= scan_cnt_reg + CW'(1);
                end
                pend_vld_reg <= issue;
                pend_idx_reg <= rd_idx;
            end
            if (cmd.capture)
            begin
                match_reg <= 1'b0;
                free_reg  <= 1'b0;
                vic_reg   <= 1'b0;
            end
            else if (search_en)
            begin
                if (cur_valid && (rd_key_reg == key_reg))
                begin
                    match_reg <= 1'b1;
                end
                if (!cur_valid && !free_reg)
                begin
                    free_reg <= 1'b1;
                end
                if (cur_valid)
                begin
                    vic_reg <= 1'b1;
                end
            end
            if (wr_en)
            begin
                valid_reg[pend_idx_reg] <= new_valid;
            end
            if (cmd.finish && insert && !evict)
            begin
                occ_reg <= occ_reg + CW'(1);
            end
        end
    end

    // request latch, search trackers and result register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req_type;
            key_reg <= key;
            val_reg <= value;
        end
        if (search_en)
        begin
            if (cur_valid && (rd_key_reg == key_reg))
            begin
                match_idx_reg  <= pend_idx_reg;
                match_val_reg  <= rd_val_reg;
                match_rank_reg <= rd_rank_reg;
            end
            if (!cur_valid && !free_reg)
            begin
                free_idx_reg <= pend_idx_reg;
            end
            if (cur_valid && (!vic_reg || (rd_cnt_reg < vic_cnt_reg) ||
                ((rd_cnt_reg == vic_cnt_reg) && (rd_rank_reg > vic_rank_reg))))
            begin
                vic_idx_reg  <= pend_idx_reg;
                vic_cnt_reg  <= rd_cnt_reg;
                vic_rank_reg <= rd_rank_reg;
                vic_key_reg  <= rd_key_reg;
            end
        end
        if (cmd.finish)
        begin
            hit_reg     <= match_reg;
            evicted_reg <= evict;
            if (req_reg == lfu_pkg::REQ_GET)
            begin
                read_value_reg <= match_reg ? match_val_reg : lfu_pkg::MISS_VALUE;
            end
            else
            begin
                read_value_reg <= '0;
            end
            evicted_key_reg <= evict ? vic_key_reg : '0;
        end
    end

    assign hit         = hit_reg;
    assign read_value  = read_value_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;

endmodule

[rtl/lfu_cache_lru_tiebreak.sv]
// top level of the lfu key-value cache with lru tie break
// depends on lfu_pkg, lfu_ctrl and lfu_dp
//
// usage:
//   requests enter on the in channel (req_type, key, value) with in_valid/in_ready;
//   one result beat per request leaves on the out channel (hit, read_value,
//   evicted, evicted_key) with out_valid/out_ready. the user writes capacity via
//   cfg_valid/cfg_ready only while no request is open; the block does not check.
// timing:
//   one request at a time; each request scans the entry memory once to find
//   the key, a free slot and the victim, one entry per cycle through the registered
//   read port; gets that miss and disabled puts finish after this search pass,
//   every request that changes the store takes a second pass.
// reset:
//   all entries invalid, occupancy zero, capacity 16, no result pending.
// stall:
//   a finished result sits in the output register while the next request is
//   accepted and searched; that request waits for out_ready before its result
//   is loaded.
module lfu_cache_lru_tiebreak #(
    parameter int ENTRIES    = lfu_pkg::DEF_ENTRIES,
    parameter int COUNT_BITS = lfu_pkg::DEF_COUNT_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             req_type,
    input  logic signed [lfu_pkg::DATA_W-1:0] key,
    input  logic signed [lfu_pkg::DATA_W-1:0] value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             hit,
    output logic signed [lfu_pkg::DATA_W-1:0] read_value,
    output logic                             evicted,
    output logic signed [lfu_pkg::DATA_W-1:0] evicted_key,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lfu_pkg::CAP_W-1:0]        capacity
);

    lfu_pkg::ctl_cmd_t cmd;
    lfu_pkg::dp_sts_t  sts;

    assign cfg_ready = 1'b1;

    lfu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    lfu_dp #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_valid),
        .cfg_data    (capacity),
        .req_type    (req_type),
        .key         (key),
        .value       (value),
        .hit         (hit),
        .read_value  (read_value),
        .evicted     (evicted),
        .evicted_key (evicted_key)
    );

endmodule

[tb/lfu_cache_lru_tiebreak_test.sv]
// testbench for lfu_cache_lru_tiebreak: directed and random get/put traffic with an
// lfu-with-lru-tiebreak predictor in a scoreboard class; capacity swept through phases
// depends on lfu_pkg and the lfu_cache_lru_tiebreak rtl
module lfu_cache_lru_tiebreak_test;

    localparam int NENT     = lfu_pkg::DEF_ENTRIES;
    localparam int CNT_MAX  = (1 << lfu_pkg::DEF_COUNT_BITS) - 1;
    localparam int SETTLE   = 2 * NENT + 20;
    localparam int LIMIT    = 400000;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_value;
        logic        evicted;
        logic [31:0] evicted_key;
    } result_t;

    class lfu_scoreboard;
        int unsigned cap;
        bit          vld[NENT];
        logic [31:0] ekey[NENT];
        logic [31:0] eval[NENT];
        int unsigned cnt[NENT];
        int unsigned rank[NENT];
        int unsigned occ;
        result_t     pending[$];
        int          errors;
        int          checked;

        function new();
            cap = lfu_pkg::CAP_RESET;
            occ = 0;
            errors = 0;
            checked = 0;
            foreach (vld[i]) vld[i] = 0;
        endfunction

        function void set_capacity(logic [lfu_pkg::CAP_W-1:0] c);
            cap = (c > NENT) ? NENT : c;
        endfunction

        function int lookup(logic [31:0] k);
            for (int i = 0; i < NENT; i++)
                if (vld[i] && ekey[i] == k) return i;
            return -1;
        endfunction

        function void touch(int i);
            for (int j = 0; j < NENT; j++)
                if (vld[j] && rank[j] < rank[i]) rank[j]++;
            rank[i] = 0;
            if (cnt[i] < CNT_MAX) cnt[i]++;
        endfunction

        function void note_request(logic rt, logic [31:0] k, logic [31:0] v);
            result_t r;
            int idx;
            int vic;
            int slot;
            idx = lookup(k);
            r = '0;
            r.hit = (idx >= 0);
            if (rt == lfu_pkg::REQ_GET) begin
                if (idx >= 0) begin
                    r.read_value = eval[idx];
                    touch(idx);
                end
                else r.read_value = lfu_pkg::MISS_VALUE;
            end
            else if (cap != 0) begin
                if (idx >= 0) begin
                    eval[idx] = v;
                    touch(idx);
                end
                else begin
                    if (occ >= cap) begin
                        vic = -1;
                        for (int i = 0; i < NENT; i++)
                            if (vld[i] && (vic < 0 || cnt[i] < cnt[vic] ||
                                (cnt[i] == cnt[vic] && rank[i] > rank[vic])))
                                vic = i;
                        if (vic >= 0) begin
                            r.evicted = 1;
                            r.evicted_key = ekey[vic];
                            vld[vic] = 0;
                            for (int i = 0; i < NENT; i++)
                                if (vld[i] && rank[i] > rank[vic]) rank[i]--;
                            occ--;
                        end
                    end
                    slot = -1;
                    for (int i = NENT - 1; i >= 0; i--)
                        if (!vld[i]) slot = i;
                    if (slot >= 0) begin
                        for (int j = 0; j < NENT; j++)
                            if (vld[j]) rank[j]++;
                        vld[slot] = 1;
                        ekey[slot] = k;
                        eval[slot] = v;
                        cnt[slot] = 1;
                        rank[slot] = 0;
                        occ++;
                    end
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t exp;
            checked++;
            if (pending.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.hit !== exp.hit) begin
                $error("hit: expected %0h actual %0h", exp.hit, got.hit);
                errors++;
            end
            if (got.read_value !== exp.read_value) begin
                $error("read_value: expected %0h actual %0h", exp.read_value, got.read_value);
                errors++;
            end
            if (got.evicted !== exp.evicted) begin
                $error("evicted: expected %0h actual %0h", exp.evicted, got.evicted);
                errors++;
            end
            if (got.evicted_key !== exp.evicted_key) begin
                $error("evicted_key: expected %0h actual %0h", exp.evicted_key,
                    got.evicted_key);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              req_type;
    logic signed [31:0] key;
    logic signed [31:0] value;
    logic              out_valid;
    logic              out_ready;
    logic              hit;
    logic signed [31:0] read_value;
    logic              evicted;
    logic signed [31:0] evicted_key;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [lfu_pkg::CAP_W-1:0] capacity;

    lfu_scoreboard sb;
    int  cycles;
    bit  sink_idle_en;
    int  sink_hold;
    bit  src_idle_en;
    int  sent;
    logic [31:0] key_pool[8];

    lfu_cache_lru_tiebreak u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .key(key), .value(value),
        .out_valid(out_valid), .out_ready(out_ready),
        .hit(hit), .read_value(read_value), .evicted(evicted), .evicted_key(evicted_key),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .capacity(capacity)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result checking at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result({hit, read_value, evicted, evicted_key});
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n) out_ready <= 1'b0;
        else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            out_ready <= 1'b0;
        end
        else out_ready <= sink_idle_en ? ($urandom_range(99) >= 36) : 1'b1;
    end

    // valid stays up between back-to-back beats; it drops only when idling or draining
    task automatic send_req(logic rt, logic [31:0] k, logic [31:0] v);
        while (src_idle_en && $urandom_range(99) < 36) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rt;
        key <= k;
        value <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_request(rt, k, v);
        sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_capacity(logic [lfu_pkg::CAP_W-1:0] c);
        drain();
        cfg_valid <= 1'b1;
        capacity <= c;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_capacity(c);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_key();
        case ($urandom_range(9))
            0: return $urandom();
            1: return 32'h8000_0000 | $urandom_range(3);
            2: return 32'h7FFF_FFFC | $urandom_range(3);
            default: return key_pool[$urandom_range(7)];
        endcase
    endfunction

    task automatic random_phase(int n);
        logic rt;
        for (int i = 0; i < n; i++) begin
            rt = 1'($urandom_range(1));
            send_req(rt, pick_key(), $urandom());
        end
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        sent = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = lfu_pkg::REQ_GET;
        key = '0;
        value = '0;
        cfg_valid = 1'b0;
        capacity = lfu_pkg::CAP_RESET;
        out_ready = 1'b0;
        sink_idle_en = 0;
        src_idle_en = 0;
        sink_hold = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, miss, hit, update, eviction
        send_req(lfu_pkg::REQ_GET, 32'h8000_0000, 32'h0);
        send_req(lfu_pkg::REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_req(lfu_pkg::REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_req(lfu_pkg::REQ_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(lfu_pkg::REQ_GET, 32'h8000_0000, 32'h0);
        send_req(lfu_pkg::REQ_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
        send_req(lfu_pkg::REQ_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        write_capacity(5'd3);
        send_req(lfu_pkg::REQ_PUT, 32'h0, 32'h5);
        send_req(lfu_pkg::REQ_PUT, 32'h1, 32'h6);
        send_req(lfu_pkg::REQ_GET, 32'h0, 32'h0);
        send_req(lfu_pkg::REQ_PUT, 32'h2, 32'h7);
        write_capacity(5'd0);
        send_req(lfu_pkg::REQ_PUT, 32'h0, 32'h9);
        send_req(lfu_pkg::REQ_PUT, 32'h55, 32'h9);
        send_req(lfu_pkg::REQ_GET, 32'h0, 32'h0);
        write_capacity(5'd1);
        send_req(lfu_pkg::REQ_PUT, 32'h66, 32'h1);
        send_req(lfu_pkg::REQ_PUT, 32'h67, 32'h2);
        write_capacity(5'd31);
        send_req(lfu_pkg::REQ_PUT, 32'h68, 32'h3);
        send_req(lfu_pkg::REQ_GET, 32'h67, 32'h0);

        foreach (key_pool[i]) key_pool[i] = $urandom();
        // long stretch with no idling, then random idling
        random_phase(150);
        sink_idle_en = 1;
        src_idle_en = 1;
        random_phase(150);

        // receiver holds off while the sender keeps offering
        sink_hold = 300;
        random_phase(40);
        drain();

        write_capacity(5'd2);
        random_phase(150);
        write_capacity(5'd16);
        foreach (key_pool[i]) key_pool[i] = $urandom_range(40);
        random_phase(200);
        write_capacity(5'd0);
        random_phase(40);
        write_capacity(5'd4);
        random_phase(150);
        write_capacity(5'd17);
        random_phase(200);

        // saturation needs 65534 touches, too slow; a hot key still gets heavy counts
        drain();
        $display("ran %0d requests, checked %0d results, capacities 0, 1-4, 16 and above",
            sent, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

[files.f]
rtl/lfu_pkg.sv
rtl/lfu_ctrl.sv
rtl/lfu_dp.sv
rtl/lfu_cache_lru_tiebreak.sv
tb/lfu_cache_lru_tiebreak_test.sv
